### rtl/core/cslc_pkg.sv
package cslc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;
    localparam int TICK_W = 7;
    localparam int MV_W = 13;
    localparam int BLINK_W = 3;
    localparam int PIN_W = 3;

    localparam int MV_STEP = 20;
    localparam int MV_BASE = 2304;

    localparam logic OP_POLL = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ON_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL2_MV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL3_MV = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL4_MV = 3'd4;

    localparam logic [TICK_W-1:0] PERIOD_TICKS_RST = 7'd110;
    localparam logic [TICK_W-1:0] ON_TICKS_RST = 7'd50;
    localparam logic [MV_W-1:0] LEVEL2_MV_RST = 13'd3800;
    localparam logic [MV_W-1:0] LEVEL3_MV_RST = 13'd4000;
    localparam logic [MV_W-1:0] LEVEL4_MV_RST = 13'd4200;

    localparam logic [PIN_W-1:0] BLUE_BIT = 3'b001;
    localparam logic [PIN_W-1:0] GREEN_BIT = 3'b010;
    localparam logic [PIN_W-1:0] RED_BIT = 3'b100;
    localparam logic [PIN_W-1:0] ALL_DARK = 3'b111;
    localparam logic [PIN_W-1:0] NO_LED = 3'b000;

    localparam logic [7:0] PWR_GOOD_MASK = 8'h04;
    localparam logic [1:0] CHG_DONE = 2'b11;
    localparam logic [7:0] FAULT_NONE = 8'h00;
    localparam logic [7:0] FAULT_COLD = 8'h01;

    typedef struct packed {
        logic [TICK_W-1:0] period_ticks;
        logic [TICK_W-1:0] on_ticks;
        logic [MV_W-1:0]   level2_mv;
        logic [MV_W-1:0]   level3_mv;
        logic [MV_W-1:0]   level4_mv;
    } cfg_t;

    typedef struct packed {
        logic [PIN_W-1:0] led_pins;
        logic             power_led;
        logic             level_showing;
    } result_t;

endpackage

### rtl/core/cslc_regs.sv
module cslc_regs
    import cslc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_ticks <= PERIOD_TICKS_RST;
            cfg_reg.on_ticks     <= ON_TICKS_RST;
            cfg_reg.level2_mv    <= LEVEL2_MV_RST;
            cfg_reg.level3_mv    <= LEVEL3_MV_RST;
            cfg_reg.level4_mv    <= LEVEL4_MV_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PERIOD_TICKS: cfg_reg.period_ticks <= cfg_data[TICK_W-1:0];
                REG_ON_TICKS:     cfg_reg.on_ticks <= cfg_data[TICK_W-1:0];
                REG_LEVEL2_MV:    cfg_reg.level2_mv <= cfg_data[MV_W-1:0];
                REG_LEVEL3_MV:    cfg_reg.level3_mv <= cfg_data[MV_W-1:0];
                REG_LEVEL4_MV:    cfg_reg.level4_mv <= cfg_data[MV_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/cslc_core.sv
module cslc_core
    import cslc_pkg::*;
#(
    parameter int ADC_BITS = 7
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                op,
    input  logic [7:0]          charger_status,
    input  logic [7:0]          fault_code,
    input  logic [ADC_BITS-1:0] battery_code,
    input  cfg_t                cfg,
    output result_t             result
);

    localparam int MV_MAX = ((1 << ADC_BITS) - 1) * MV_STEP + MV_BASE;
    localparam int ADC_MV_W = $clog2(MV_MAX + 1);
    localparam int CMP_W = (ADC_MV_W > MV_W) ? ADC_MV_W : MV_W;

    logic [TICK_W-1:0]  tick_count_reg, tick_count_next;
    logic               show_request_reg, show_request_next;
    logic [BLINK_W-1:0] blinks_left_reg, blinks_left_next;
    logic [PIN_W-1:0]   status_mask_reg, status_mask_next;
    logic               flash_mode_reg, flash_mode_next;
    logic               power_on_reg, power_on_next;
    logic               fault_now_reg, fault_now_next;
    logic               fault_before_reg, fault_before_next;
    logic               started_reg, started_next;
    logic [PIN_W-1:0]   pin_levels_reg, pin_levels_next;

    logic [CMP_W-1:0]   mv;
    logic [BLINK_W-1:0] level;
    logic [TICK_W:0]    tick_inc;
    logic               pg;

    assign mv = CMP_W'(battery_code) * CMP_W'(MV_STEP) + CMP_W'(MV_BASE);
    assign pg = (charger_status & PWR_GOOD_MASK) != 8'h00;

    always_comb
    begin
        level = BLINK_W'(1);
        if (mv > CMP_W'(cfg.level2_mv)) level = BLINK_W'(2);
        if (mv > CMP_W'(cfg.level3_mv)) level = BLINK_W'(3);
        if (mv > CMP_W'(cfg.level4_mv)) level = BLINK_W'(4);
    end

    always_comb
    begin
        tick_count_next   = tick_count_reg;
        show_request_next = show_request_reg;
        blinks_left_next  = blinks_left_reg;
        status_mask_next  = status_mask_reg;
        flash_mode_next   = flash_mode_reg;
        power_on_next     = power_on_reg;
        fault_now_next    = fault_now_reg;
        fault_before_next = fault_before_reg;
        started_next      = started_reg;
        pin_levels_next   = pin_levels_reg;
        tick_inc          = {1'b0, tick_count_reg} + (TICK_W+1)'(1);

        unique case (op)
            OP_POLL:
            begin
                power_on_next = pg;
                if (pg)
                begin
                    if (fault_code == FAULT_NONE)
                    begin
                        status_mask_next = GREEN_BIT;
                        flash_mode_next  = charger_status[4:3] != CHG_DONE;
                    end
                    else if (fault_code == FAULT_COLD && battery_code == '0)
                    begin
                        status_mask_next = NO_LED;
                        flash_mode_next  = 1'b0;
                    end
                    else
                    begin
                        status_mask_next = RED_BIT;
                        flash_mode_next  = 1'b0;
                    end
                end
                fault_before_next = fault_now_reg;
                fault_now_next    = fault_code[0];
                if ((!fault_code[0] && fault_now_reg) ||
                    (!started_reg && fault_code == FAULT_NONE && pg))
                begin
                    started_next      = 1'b1;
                    show_request_next = 1'b1;
                    tick_count_next   = '0;
                end
            end
            OP_TICK:
            begin
                if (tick_inc >= {1'b0, cfg.period_ticks})
                begin
                    tick_inc = '0;
                    if (show_request_reg)
                    begin
                        blinks_left_next  = level;
                        show_request_next = 1'b0;
                    end
                    if (blinks_left_next != '0)
                        blinks_left_next = blinks_left_next - BLINK_W'(1);
                end
                tick_count_next = tick_inc[TICK_W-1:0];
                if (!show_request_next && blinks_left_next == '0)
                begin
                    if (flash_mode_reg && tick_count_next >= cfg.on_ticks)
                        pin_levels_next = ALL_DARK;
                    else
                        pin_levels_next = ALL_DARK & ~status_mask_reg;
                end
                else
                begin
                    pin_levels_next = (tick_count_next < cfg.on_ticks) ?
                                      (ALL_DARK & ~BLUE_BIT) : ALL_DARK;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg   <= '0;
            show_request_reg <= 1'b0;
            blinks_left_reg  <= '0;
            status_mask_reg  <= NO_LED;
            flash_mode_reg   <= 1'b0;
            power_on_reg     <= 1'b0;
            fault_now_reg    <= 1'b0;
            fault_before_reg <= 1'b0;
            started_reg      <= 1'b0;
            pin_levels_reg   <= ALL_DARK;
        end
        else if (accept)
        begin
            tick_count_reg   <= tick_count_next;
            show_request_reg <= show_request_next;
            blinks_left_reg  <= blinks_left_next;
            status_mask_reg  <= status_mask_next;
            flash_mode_reg   <= flash_mode_next;
            power_on_reg     <= power_on_next;
            fault_now_reg    <= fault_now_next;
            fault_before_reg <= fault_before_next;
            started_reg      <= started_next;
            pin_levels_reg   <= pin_levels_next;
        end
    end

    assign result.led_pins      = pin_levels_next;
    assign result.power_led     = power_on_next;
    assign result.level_showing = show_request_next || (blinks_left_next != '0);

    // blink count is decremented on the same wrap that loads it
    a_blinks_max: assert property (@(posedge clk) disable iff (!rst_n)
        blinks_left_reg <= BLINK_W'(3))
        else $error("blink count above three");

    a_pins_hold_on_poll: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == OP_POLL |=> $stable(pin_levels_reg))
        else $error("poll changed LED pins");

    a_request_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        show_request_reg |-> started_reg)
        else $error("level request without start");

    a_mask_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(status_mask_reg) && (status_mask_reg & BLUE_BIT) == NO_LED)
        else $error("bad status color");

endmodule

### rtl/core/cslc_outbuf.sv
module cslc_outbuf
    import cslc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    head_valid_reg, head_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t head_reg, head_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop = head_valid_reg && !out_stall;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (!head_valid_reg)
        begin
            head_valid_next = push;
            head_next       = push_data;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = push;
                skid_next       = push_data;
            end
            else
            begin
                head_valid_next = push;
                head_next       = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

    a_skid_implies_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry without head entry");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("transaction pushed into full buffer");

    a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid_reg && out_stall |=> head_valid_reg && $stable(head_reg))
        else $error("stalled result changed");

endmodule

### rtl/core/charger_status_led_controller.sv
// Charger status LED controller.
// Input channel (in_valid/in_stall) carries one transaction per poll sample
// (op=0: charger_status, fault_code, battery_code) or timer tick (op=1).
// Every input transaction yields exactly one output transaction
// (out_valid/out_stall) with led_pins (active low blue/green/red),
// power_led and level_showing, in input order.
// Configuration: cfg_we writes cfg_data to register cfg_index
// (0 period_ticks, 1 on_ticks, 2..4 level2/3/4_mv); other indexes ignored.
// Each result is registered in the output buffer before it is presented.
// Throughput: one transaction per cycle while in_stall is low; the controller
// state updates once per accepted transaction and a two-entry output buffer
// decouples the channels.
// Output stall: results queue in the buffer; in_stall rises only once both
// entries are held.
// Reset: LEDs dark, power LED off, counters and requests cleared, registers
// at their defaults (110, 50, 3800, 4000, 4200).
module charger_status_led_controller
    import cslc_pkg::*;
#(
    parameter int ADC_BITS = 7
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic [7:0]            charger_status,
    input  logic [7:0]            fault_code,
    input  logic [ADC_BITS-1:0]   battery_code,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIN_W-1:0]      led_pins,
    output logic                  power_led,
    output logic                  level_showing,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    result_t core_result;
    result_t out_data;
    logic    accept;
    logic    full;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    cslc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cslc_core #(
        .ADC_BITS (ADC_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .op             (op),
        .charger_status (charger_status),
        .fault_code     (fault_code),
        .battery_code   (battery_code),
        .cfg            (cfg),
        .result         (core_result)
    );

    cslc_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (core_result),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign led_pins      = out_data.led_pins;
    assign power_led     = out_data.power_led;
    assign level_showing = out_data.level_showing;

endmodule

### dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cslc_pkg::*;

    localparam int WATCHDOG_CYCLES = 1000;
    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 95;
    localparam int NUM_ROWS = 30;
    localparam int MV_TOP = MV_BASE + 127 * MV_STEP;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic                 op;
        logic [7:0]           stat;
        logic [7:0]           fault;
        logic [6:0]           code;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] value;
        bit                   typed;
        result_t              exp;
    } step_row_t;

    localparam result_t DARK_OFF = '{ALL_DARK, 1'b0, 1'b0};
    localparam result_t DARK_PWR_SHOW = '{ALL_DARK, 1'b1, 1'b1};
    localparam result_t NO_CHECK = '0;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic op = OP_POLL;
    logic [7:0] charger_status = '0;
    logic [7:0] fault_code = '0;
    logic [6:0] battery_code = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [PIN_W-1:0] led_pins;
    logic power_led;
    logic level_showing;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_PERIOD_TICKS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predicted controller state and register copies
    logic [6:0] tick_ctr = '0;
    logic show_pending = 1'b0;
    logic [2:0] blinks_rem = '0;
    logic [PIN_W-1:0] color_mask = NO_LED;
    logic flashing = 1'b0;
    logic pwr_led_st = 1'b0;
    logic cold_now = 1'b0;
    logic cold_prev = 1'b0;
    logic seen_healthy = 1'b0;
    logic [PIN_W-1:0] pin_state = ALL_DARK;
    logic [TICK_W-1:0] period_cfg = PERIOD_TICKS_RST;
    logic [TICK_W-1:0] on_cfg = ON_TICKS_RST;
    logic [MV_W-1:0] lvl2_cfg = LEVEL2_MV_RST;
    logic [MV_W-1:0] lvl3_cfg = LEVEL3_MV_RST;
    logic [MV_W-1:0] lvl4_cfg = LEVEL4_MV_RST;

    result_t led_expect_q[$];
    int err_count = 0;
    int n_polls = 0;
    int n_ticks = 0;
    int n_checked = 0;
    int n_writes = 0;
    int idle_cycles = 0;
    bit quiet = 1'b0;

    step_row_t script [NUM_ROWS] = '{
        '{ROW_ITEM, OP_TICK, 8'h00, 8'h00, 7'd0,   REG_PERIOD_TICKS, 13'd0, 1'b1, DARK_OFF},
        '{ROW_ITEM, OP_POLL, 8'h00, 8'hFF, 7'd127, REG_PERIOD_TICKS, 13'd0, 1'b1, DARK_OFF},
        '{ROW_ITEM, OP_POLL, 8'hFF, 8'h00, 7'd0,   REG_PERIOD_TICKS, 13'd0, 1'b1, DARK_PWR_SHOW},
        '{ROW_ITEM, OP_TICK, 8'hFF, 8'hFF, 7'd127, REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK},
        '{ROW_CFG,  OP_POLL, 8'h00, 8'h00, 7'd0,   REG_PERIOD_TICKS, 13'd1, 1'b0, NO_CHECK},
        '{ROW_CFG,  OP_POLL, 8'h00, 8'h00, 7'd0,   REG_ON_TICKS,     13'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_TICK, 8'h00, 8'h00, 7'd127, REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_TICK, 8'h00, 8'h00, 7'd0,   REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_POLL, 8'h04, 8'h01, 7'd0,   REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_TICK, 8'h00, 8'h00, 7'd0,   REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_TICK, 8'h00, 8'h00, 7'd0,   REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_POLL, 8'h04, 8'h01, 7'd1,   REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_TICK, 8'h00, 8'h00, 7'd0,   REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_POLL, 8'h00, 8'h00, 7'd5,   REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_POLL, 8'h04, 8'h02, 7'd0,   REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_TICK, 8'h00, 8'h00, 7'd64,  REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_POLL, 8'h04, 8'h00, 7'd64,  REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK},
        '{ROW_CFG,  OP_POLL, 8'h00, 8'h00, 7'd0,   REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK},
        '{ROW_CFG,  OP_POLL, 8'h00, 8'h00, 7'd0,   REG_ON_TICKS,   13'd127, 1'b0, NO_CHECK},
        '{ROW_CFG,  OP_POLL, 8'h00, 8'h00, 7'd0,   REG_LEVEL2_MV, 13'd2304, 1'b0, NO_CHECK},
        '{ROW_CFG,  OP_POLL, 8'h00, 8'h00, 7'd0,   REG_LEVEL3_MV, 13'd2304, 1'b0, NO_CHECK},
        '{ROW_CFG,  OP_POLL, 8'h00, 8'h00, 7'd0,   REG_LEVEL4_MV, 13'd4844, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_POLL, 8'h04, 8'h01, 7'd9,   REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_POLL, 8'h1C, 8'h00, 7'd1,   REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_TICK, 8'h00, 8'h00, 7'd1,   REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_TICK, 8'h00, 8'h00, 7'd0,   REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_TICK, 8'h00, 8'h00, 7'd0,   REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_TICK, 8'h00, 8'h00, 7'd0,   REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_POLL, 8'h04, 8'h00, 7'd127, REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK},
        '{ROW_ITEM, OP_TICK, 8'h00, 8'h00, 7'd0,   REG_PERIOD_TICKS, 13'd0, 1'b0, NO_CHECK}
    };

    charger_status_led_controller uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .charger_status (charger_status),
        .fault_code     (fault_code),
        .battery_code   (battery_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .led_pins       (led_pins),
        .power_led      (power_led),
        .level_showing  (level_showing),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [2:0] blink_count(input int mv);
        logic [2:0] lvl;
        lvl = 3'd1;
        if (mv > int'(lvl2_cfg)) lvl = 3'd2;
        if (mv > int'(lvl3_cfg)) lvl = 3'd3;
        if (mv > int'(lvl4_cfg)) lvl = 3'd4;
        return lvl;
    endfunction

    function automatic result_t advance_led_state(input logic o, input logic [7:0] s,
                                                  input logic [7:0] f, input logic [6:0] c);
        bit pg;
        int mv;
        int nxt;
        result_t r;
        mv = int'(c) * MV_STEP + MV_BASE;
        if (o == OP_POLL)
        begin
            pg = (s & PWR_GOOD_MASK) != 0;
            if (pg)
            begin
                pwr_led_st = 1'b1;
                if (f == FAULT_NONE)
                begin
                    color_mask = GREEN_BIT;
                    flashing = (s[4:3] != CHG_DONE);
                end
                else if (f == FAULT_COLD && c == 0)
                begin
                    color_mask = NO_LED;
                    flashing = 1'b0;
                end
                else
                begin
                    color_mask = RED_BIT;
                    flashing = 1'b0;
                end
            end
            else
            begin
                pwr_led_st = 1'b0;
            end
            cold_prev = cold_now;
            cold_now = f[0];
            if ((!cold_now && cold_prev) || (!seen_healthy && f == FAULT_NONE && pg))
            begin
                seen_healthy = 1'b1;
                show_pending = 1'b1;
                tick_ctr = '0;
            end
        end
        else
        begin
            nxt = int'(tick_ctr) + 1;
            if (nxt >= int'(period_cfg))
            begin
                nxt = 0;
                if (show_pending)
                begin
                    blinks_rem = blink_count(mv);
                    show_pending = 1'b0;
                end
                if (blinks_rem != 0) blinks_rem = blinks_rem - 3'd1;
            end
            tick_ctr = 7'(nxt);
            if (!show_pending && blinks_rem == 0)
                pin_state = (flashing && tick_ctr >= on_cfg) ? ALL_DARK : (ALL_DARK & ~color_mask);
            else
                pin_state = (tick_ctr < on_cfg) ? (ALL_DARK & ~BLUE_BIT) : ALL_DARK;
        end
        r.led_pins = pin_state;
        r.power_led = pwr_led_st;
        r.level_showing = show_pending || (blinks_rem != 0);
        return r;
    endfunction

    task automatic send_item(input logic o, input logic [7:0] s, input logic [7:0] f,
                             input logic [6:0] c, input bit typed, input result_t exp);
        result_t r;
        if (!quiet && $urandom_range(0, 99) < 23)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        charger_status <= s;
        fault_code <= f;
        battery_code <= c;
        do
            @(posedge clk);
        while (in_stall);
        r = advance_led_state(o, s, f, c);
        led_expect_q.push_back(typed ? exp : r);
        if (o == OP_TICK) n_ticks++;
        else n_polls++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (led_expect_q.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PERIOD_TICKS: period_cfg = val[TICK_W-1:0];
            REG_ON_TICKS:     on_cfg = val[TICK_W-1:0];
            REG_LEVEL2_MV:    lvl2_cfg = val[MV_W-1:0];
            REG_LEVEL3_MV:    lvl3_cfg = val[MV_W-1:0];
            REG_LEVEL4_MV:    lvl4_cfg = val[MV_W-1:0];
            default:          ;
        endcase
        n_writes++;
        @(posedge clk);
    endtask

    task automatic send_random_item();
        logic o;
        logic [7:0] s;
        logic [7:0] f;
        logic [6:0] c;
        int pick;
        o = ($urandom_range(0, 99) < 65) ? OP_TICK : OP_POLL;
        s = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 80) s = s | PWR_GOOD_MASK;
        else s = s & ~PWR_GOOD_MASK;
        pick = $urandom_range(0, 9);
        if (pick < 5) f = FAULT_NONE;
        else if (pick < 8) f = FAULT_COLD;
        else f = 8'($urandom_range(0, 255));
        c = ($urandom_range(0, 99) < 20) ? 7'd0 : 7'($urandom_range(0, 127));
        send_item(o, s, f, c, 1'b0, NO_CHECK);
    endtask

    always @(posedge clk)
        out_stall <= !quiet && ($urandom_range(0, 99) < 23);

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (led_expect_q.size() == 0)
            begin
                $error("output transaction with nothing expected: pins %0d pwr %0d show %0d",
                       led_pins, power_led, level_showing);
                err_count++;
            end
            else
            begin
                want = led_expect_q.pop_front();
                n_checked++;
                if (led_pins !== want.led_pins)
                begin
                    $error("led_pins: expected %0d, got %0d", want.led_pins, led_pins);
                    err_count++;
                end
                if (power_led !== want.power_led)
                begin
                    $error("power_led: expected %0d, got %0d", want.power_led, power_led);
                    err_count++;
                end
                if (level_showing !== want.level_showing)
                begin
                    $error("level_showing: expected %0d, got %0d",
                           want.level_showing, level_showing);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int per;
        int on;
        int l2;
        int l3;
        int l4;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(script[i].reg_idx, script[i].value);
            end
            else
            begin
                send_item(script[i].op, script[i].stat, script[i].fault, script[i].code,
                          script[i].typed, script[i].exp);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            l2 = $urandom_range(MV_BASE, MV_TOP);
            l3 = $urandom_range(MV_BASE, MV_TOP);
            l4 = $urandom_range(MV_BASE, MV_TOP);
            case (ph)
                0:
                begin
                    per = 1;
                    on = 0;
                    l2 = MV_BASE;
                    l3 = MV_BASE;
                    l4 = MV_BASE;
                end
                1:
                begin
                    per = 127;
                    on = 127;
                    l2 = MV_TOP;
                    l3 = MV_TOP;
                    l4 = MV_TOP;
                end
                2:
                begin
                    per = 0;
                    on = $urandom_range(0, 10);
                end
                default:
                begin
                    per = $urandom_range(2, 24);
                    on = $urandom_range(0, per);
                end
            endcase
            write_reg(REG_PERIOD_TICKS, CFG_DATA_W'(per));
            write_reg(REG_ON_TICKS, CFG_DATA_W'(on));
            write_reg(REG_LEVEL2_MV, CFG_DATA_W'(l2));
            write_reg(REG_LEVEL3_MV, CFG_DATA_W'(l3));
            write_reg(REG_LEVEL4_MV, CFG_DATA_W'(l4));
            // one phase runs back to back with no gaps on either side
            quiet = (ph == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_item();
            quiet = 1'b0;
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (led_expect_q.size() != 0)
        begin
            $error("%0d expected results never arrived", led_expect_q.size());
            err_count++;
        end
        $display("covered %0d polls and %0d ticks, %0d results compared",
                 n_polls, n_ticks, n_checked);
        $display("over %0d register writes incl. zero and full-scale period and thresholds",
                 n_writes);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/core/cslc_pkg.sv
rtl/core/cslc_regs.sv
rtl/core/cslc_core.sv
rtl/core/cslc_outbuf.sv
rtl/core/charger_status_led_controller.sv
dv/tb.sv
